// ===== src/fpot_pkg.sv =====
// Shared types and constants of the fill position and open-order tracker.
// Used by the controller, the datapath and the top level; no dependencies.
package fpot_pkg;

  // Report kinds carried in the input tuser.
  localparam logic [2:0] KIND_NEW    = 3'd0;
  localparam logic [2:0] KIND_FILL   = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_LOAD   = 3'd4;

  localparam int ACC_W    = 128;
  localparam int CNT_W    = 6;

  // Number of 16-bit multiplier passes per operand and divider iterations.
  localparam logic [CNT_W-1:0] STEPS_ENTRY = 6'd3;
  localparam logic [CNT_W-1:0] STEPS_PX    = 6'd2;
  localparam logic [CNT_W-1:0] STEPS_DIFF  = 6'd3;
  localparam logic [CNT_W-1:0] STEPS_CS    = 6'd6;
  localparam logic [CNT_W-1:0] STEPS_DIV   = 6'd48;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_OVERWRITE      = 3'd1,
    ST_FILL_UNKNOWN   = 3'd2,
    ST_REMOVE_UNKNOWN = 3'd3,
    ST_TABLE_FULL     = 3'd4,
    ST_IGNORED        = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    FC_SIMPLE = 3'd0,
    FC_AVG    = 3'd1,
    FC_CLOSE  = 3'd2,
    FC_REDUCE = 3'd3,
    FC_FLIP   = 3'd4
  } fill_case_t;

  typedef enum logic [1:0] {
    MS_ENTRY = 2'd0,
    MS_PX    = 2'd1,
    MS_DIFF  = 2'd2,
    MS_CS    = 2'd3
  } mul_sel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LD_E, S_STEP_E, S_LD_P, S_STEP_P, S_DIV_INIT, S_DIV_STEP,
    S_LD_D, S_STEP_D, S_LD_C, S_STEP_C, S_FILL_COMMIT, S_SCAN_START, S_SCAN_WAIT,
    S_SLOT_APPLY, S_LOAD_POS, S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic     capture;
    logic     mul_load;
    mul_sel_t mul_sel;
    logic     mul_step;
    logic     div_init;
    logic     div_step;
    logic     fill_commit;
    logic     load_commit;
    logic     scan_start;
    logic     slot_apply;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    fill_case_t fill_case;
    logic       scan_busy;
    logic       out_full;
  } dp_stat_t;

endpackage

// ===== src/fpot_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpot_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/fpot_ctrl.sv =====
// Controller state machine of the tracker: sequences multiply passes,
// divider iterations, the table scan and the result handoff. Uses fpot_pkg.
module fpot_ctrl import fpot_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  ctrl_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic step_last;

  always_comb begin
    case (state_r)
      S_STEP_E:   step_last = (cnt_r == STEPS_ENTRY - 6'd1);
      S_STEP_P:   step_last = (cnt_r == STEPS_PX - 6'd1);
      S_STEP_D:   step_last = (cnt_r == STEPS_DIFF - 6'd1);
      S_STEP_C:   step_last = (cnt_r == STEPS_CS - 6'd1);
      S_DIV_STEP: step_last = (cnt_r == STEPS_DIV - 6'd1);
      default:    step_last = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_tvalid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (stat.kind == KIND_FILL) begin
          case (stat.fill_case)
            FC_SIMPLE: state_nxt = S_FILL_COMMIT;
            FC_AVG:    state_nxt = S_LD_E;
            default:   state_nxt = S_LD_D;
          endcase
        end else if (stat.kind == KIND_NEW || stat.kind == KIND_REMOVE) begin
          state_nxt = S_SCAN_START;
        end else if (stat.kind == KIND_LOAD) begin
          state_nxt = S_LOAD_POS;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_LD_E:        state_nxt = S_STEP_E;
      S_STEP_E:      if (step_last) state_nxt = S_LD_P;
      S_LD_P:        state_nxt = S_STEP_P;
      S_STEP_P:      if (step_last) state_nxt = S_DIV_INIT;
      S_DIV_INIT:    state_nxt = S_DIV_STEP;
      S_DIV_STEP:    if (step_last) state_nxt = S_FILL_COMMIT;
      S_LD_D:        state_nxt = S_STEP_D;
      S_STEP_D:      if (step_last) state_nxt = S_LD_C;
      S_LD_C:        state_nxt = S_STEP_C;
      S_STEP_C:      if (step_last) state_nxt = S_FILL_COMMIT;
      S_FILL_COMMIT: state_nxt = S_SCAN_START;
      S_SCAN_START:  state_nxt = S_SCAN_WAIT;
      S_SCAN_WAIT:   if (!stat.scan_busy) state_nxt = S_SLOT_APPLY;
      S_SLOT_APPLY:  state_nxt = S_FINISH;
      S_LOAD_POS:    state_nxt = S_FINISH;
      S_FINISH:      if (!stat.out_full) state_nxt = S_IDLE;
      default:       state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_LD_E: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MS_ENTRY;
      end
      S_LD_P: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MS_PX;
      end
      S_LD_D: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MS_DIFF;
      end
      S_LD_C: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MS_CS;
      end
      S_STEP_E, S_STEP_P, S_STEP_D, S_STEP_C: cmd.mul_step = 1'b1;
      S_DIV_INIT:    cmd.div_init    = 1'b1;
      S_DIV_STEP:    cmd.div_step    = 1'b1;
      S_FILL_COMMIT: cmd.fill_commit = 1'b1;
      S_SCAN_START:  cmd.scan_start  = 1'b1;
      S_SLOT_APPLY:  cmd.slot_apply  = 1'b1;
      S_LOAD_POS:    cmd.load_commit = 1'b1;
      S_FINISH:      cmd.out_load    = !stat.out_full;
      default:       cmd             = '0;
    endcase
  end

  assign cnt_nxt = step_last ? '0 : cnt_r + 6'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end
endmodule

// ===== src/fpot_dp.sv =====
// Datapath of the tracker: position, price and profit registers, a 50x16
// multiply-accumulate unit, a radix-2 divider, the open-order table scan and
// the output register. Uses fpot_pkg and fpot_ram.
module fpot_dp import fpot_pkg::*; #(
  parameter int ORDER_SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  dp_cmd_t      cmd,
  output dp_stat_t     stat,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic [2:0]   in_kind,
  input  logic [63:0]  in_order_id,
  input  logic [31:0]  in_qty,
  input  logic [47:0]  in_price,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [47:0]  out_position_qty,
  output logic [47:0]  out_average_price,
  output logic [63:0]  out_realized_profit,
  output logic [4:0]   out_open_order_count,
  output logic [2:0]   out_status
);
  localparam int SW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int CW = $clog2(ORDER_SLOTS + 1);

  // Architectural state.
  logic [15:0] cs_r;
  logic [47:0] pos_r, ent_r;
  logic [63:0] prof_r;
  logic [ORDER_SLOTS-1:0] valid_r;
  logic [CW-1:0] count_r;

  // Captured transaction.
  logic [2:0]  kind_r;
  logic [63:0] id_r;
  logic [31:0] q_r;
  logic [47:0] px_r;
  status_t     st_r;

  // Arithmetic units.
  logic [49:0]      a_r;
  logic [95:0]      b_r;
  logic [2:0]       k_r;
  logic [ACC_W-1:0] acc_r;
  logic             neg_r;
  logic [48:0]      rem_r, d_r;
  logic [47:0]      nq_r;

  // Table scan.
  logic          scan_act_r, cmp_v_r, hit_r, free_r;
  logic [SW-1:0] scan_idx_r, cmp_idx_r, hit_idx_r, free_idx_r;
  logic [31:0]   hit_qty_r;
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [95:0]   ram_wdata, ram_rdata;

  // Output register.
  logic        out_valid_r;
  logic [47:0] out_pos_r, out_avg_r;
  logic [63:0] out_prof_r;
  logic [4:0]  out_cnt_r;
  logic [2:0]  out_st_r;

  // Fill classification.
  logic [48:0] sum49, diff49, dsum;
  logic [47:0] m_mag, cov_mag, pos_sat;
  logic [31:0] q_mag;
  logic [48:0] diff_mag;
  logic        m_zero, q_zero, m_neg, q_neg, cov_neg, prof_neg;
  fill_case_t  fc;

  assign m_neg  = pos_r[47];
  assign q_neg  = q_r[31];
  assign m_zero = (pos_r == '0);
  assign q_zero = (q_r == '0);
  assign sum49  = {pos_r[47], pos_r} + {{17{q_r[31]}}, q_r};
  assign m_mag  = m_neg ? 48'd0 - pos_r : pos_r;
  assign q_mag  = q_neg ? 32'd0 - q_r : q_r;
  assign dsum   = {1'b0, m_mag} + {17'b0, q_mag};
  assign diff49 = {px_r[47], px_r} - {ent_r[47], ent_r};
  assign diff_mag = diff49[48] ? 49'd0 - diff49 : diff49;

  always_comb begin
    if (m_zero || q_zero) begin
      fc = FC_SIMPLE;
    end else if (m_neg == q_neg) begin
      fc = FC_AVG;
    end else if (sum49 == '0) begin
      fc = FC_CLOSE;
    end else if (sum49[48] == m_neg) begin
      fc = FC_REDUCE;
    end else begin
      fc = FC_FLIP;
    end
  end

  // Profit is booked on the covered part: the fill itself when the position
  // only shrinks, otherwise the whole old position.
  assign cov_mag  = (fc == FC_REDUCE) ? {16'b0, q_mag} : m_mag;
  assign cov_neg  = (fc == FC_REDUCE) ? !q_neg : m_neg;
  assign prof_neg = cov_neg != diff49[48];

  always_comb begin
    if (sum49[48] != sum49[47]) begin
      pos_sat = sum49[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      pos_sat = sum49[47:0];
    end
  end

  // Multiply-accumulate: one 50x16 signed partial product per cycle.
  logic signed [66:0] prod;
  logic [ACC_W-1:0]   prod_ext;
  assign prod     = $signed(a_r) * $signed({1'b0, b_r[15:0]});
  assign prod_ext = {{(ACC_W-67){prod[66]}}, prod} << {k_r, 4'b0000};

  // Divider: restoring, one quotient bit per cycle.
  logic [49:0]      dv_t;
  logic             dv_ge;
  logic [ACC_W-1:0] acc_mag;
  assign dv_t    = {rem_r, nq_r[47]};
  assign dv_ge   = dv_t >= {1'b0, d_r};
  assign acc_mag = acc_r[ACC_W-1] ? '0 - acc_r : acc_r;

  // Profit update with saturation to 64 bits.
  logic [ACC_W-1:0] delta, psum;
  logic [63:0]      prof_sat;
  assign delta = prof_neg ? '0 - acc_r : acc_r;
  assign psum  = {{(ACC_W-64){prof_r[63]}}, prof_r} + delta;
  always_comb begin
    if (psum[ACC_W-1:63] == {(ACC_W-63){psum[63]}}) begin
      prof_sat = psum[63:0];
    end else begin
      prof_sat = psum[ACC_W-1] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
  end

  logic [31:0] fill_left;
  assign fill_left = hit_qty_r - q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r   <= 16'd1;
      pos_r  <= '0;
      ent_r  <= '0;
      prof_r <= '0;
    end else begin
      if (cfg_we) begin
        cs_r <= cfg_wdata;
      end
      if (cmd.fill_commit) begin
        pos_r <= pos_sat;
        case (fc)
          FC_SIMPLE: if (m_zero) ent_r <= px_r;
          FC_AVG:    ent_r <= neg_r ? 48'd0 - nq_r : nq_r;
          FC_CLOSE:  ent_r <= '0;
          FC_FLIP:   ent_r <= px_r;
          default:   ent_r <= ent_r;
        endcase
        if (fc == FC_CLOSE || fc == FC_REDUCE || fc == FC_FLIP) begin
          prof_r <= prof_sat;
        end
      end else if (cmd.load_commit) begin
        pos_r  <= {{16{q_r[31]}}, q_r};
        ent_r  <= px_r;
        prof_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      id_r   <= in_order_id;
      q_r    <= in_qty;
      px_r   <= in_price;
    end
    if (cmd.mul_load) begin
      k_r <= '0;
      case (cmd.mul_sel)
        MS_ENTRY: begin
          a_r   <= {{2{ent_r[47]}}, ent_r};
          b_r   <= {48'b0, m_mag};
          acc_r <= '0;
        end
        MS_PX: begin
          a_r <= {{2{px_r[47]}}, px_r};
          b_r <= {64'b0, q_mag};
        end
        MS_DIFF: begin
          a_r   <= {1'b0, diff_mag};
          b_r   <= {48'b0, cov_mag};
          acc_r <= '0;
        end
        default: begin
          a_r   <= {34'b0, cs_r};
          b_r   <= acc_r[95:0];
          acc_r <= '0;
        end
      endcase
    end else if (cmd.mul_step) begin
      acc_r <= acc_r + prod_ext;
      b_r   <= {16'b0, b_r[95:16]};
      k_r   <= k_r + 3'd1;
    end
    if (cmd.div_init) begin
      // The quotient is a weighted mean of two 48-bit prices, so the upper
      // half of the dividend is already below the divisor.
      neg_r <= acc_r[ACC_W-1];
      rem_r <= acc_mag[96:48];
      nq_r  <= acc_mag[47:0];
      d_r   <= dsum;
    end else if (cmd.div_step) begin
      rem_r <= dv_ge ? 49'(dv_t - {1'b0, d_r}) : dv_t[48:0];
      nq_r  <= {nq_r[46:0], dv_ge};
    end
  end

  // Table scan: one entry read per cycle, compared on the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_act_r <= 1'b0;
      cmp_v_r    <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_act_r <= 1'b1;
      end else if (scan_act_r && scan_idx_r == SW'(ORDER_SLOTS - 1)) begin
        scan_act_r <= 1'b0;
      end
      cmp_v_r <= scan_act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
    end else begin
      if (scan_act_r) begin
        scan_idx_r <= scan_idx_r + SW'(1);
      end
      if (cmp_v_r) begin
        if (valid_r[cmp_idx_r] && ram_rdata[95:32] == id_r && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= cmp_idx_r;
          hit_qty_r <= ram_rdata[31:0];
        end
        if (!valid_r[cmp_idx_r] && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= cmp_idx_r;
        end
      end
    end
    cmp_idx_r <= scan_idx_r;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_idx_r;
    ram_wdata = {id_r, q_r};
    if (cmd.slot_apply) begin
      if (kind_r == KIND_NEW) begin
        ram_we    = hit_r || free_r;
        ram_waddr = hit_r ? hit_idx_r : free_idx_r;
      end else if (kind_r == KIND_FILL) begin
        ram_we    = hit_r;
        ram_wdata = {id_r, fill_left};
      end
    end
  end

  fpot_ram #(.WIDTH(96), .DEPTH(ORDER_SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      st_r    <= ST_OK;
    end else if (cmd.capture) begin
      if (in_kind == KIND_NEW || in_kind == KIND_FILL || in_kind == KIND_REMOVE ||
          in_kind == KIND_LOAD) begin
        st_r <= ST_OK;
      end else begin
        st_r <= ST_IGNORED;
      end
    end else if (cmd.slot_apply) begin
      case (kind_r)
        KIND_NEW: begin
          if (hit_r) begin
            st_r <= ST_OVERWRITE;
          end else if (free_r) begin
            valid_r[free_idx_r] <= 1'b1;
            count_r <= count_r + CW'(1);
          end else begin
            st_r <= ST_TABLE_FULL;
          end
        end
        KIND_FILL: begin
          if (!hit_r) begin
            st_r <= ST_FILL_UNKNOWN;
          end else if (fill_left == '0) begin
            valid_r[hit_idx_r] <= 1'b0;
            count_r <= count_r - CW'(1);
          end
        end
        KIND_REMOVE: begin
          if (hit_r) begin
            valid_r[hit_idx_r] <= 1'b0;
            count_r <= count_r - CW'(1);
          end else begin
            st_r <= ST_REMOVE_UNKNOWN;
          end
        end
        default: st_r <= st_r;
      endcase
    end
  end

  logic [CW+4:0] cnt_ext;
  assign cnt_ext = {5'b0, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pos_r  <= pos_r;
      out_avg_r  <= ent_r;
      out_prof_r <= prof_r;
      out_cnt_r  <= (cnt_ext > (CW+5)'(31)) ? 5'd31 : cnt_ext[4:0];
      out_st_r   <= st_r;
    end
  end

  assign stat.kind      = kind_r;
  assign stat.fill_case = fc;
  assign stat.scan_busy = scan_act_r | cmp_v_r;
  assign stat.out_full  = out_valid_r & ~out_ready;

  assign out_valid            = out_valid_r;
  assign out_position_qty     = out_pos_r;
  assign out_average_price    = out_avg_r;
  assign out_realized_profit  = out_prof_r;
  assign out_open_order_count = out_cnt_r;
  assign out_status           = out_st_r;
endmodule

// ===== src/fill_position_and_open_order_tracker.sv =====
// Position and open-order tracker top level; one transaction in flight at a time.
// Ignored reports go straight to the result register; loads first set position, price
// and profit; new and remove orders scan the order table; a plain fill commits and then
// scans; a profit-booking fill first runs the price-difference and contract-size multiplies,
// and an averaging fill the entry and price multiplies and the 48-step divider.
// A new transaction is taken only once the result is loaded; a stalled result holds the input.
// Synchronous reset clears position, price, profit, the table and contract size to 1.
module fill_position_and_open_order_tracker import fpot_pkg::*; #(
  parameter int ORDER_SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: order_id[63:0], qty[95:64], price[143:96], timestamp[207:144]
  input  logic [207:0] in_tdata,
  // tuser: kind[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: position_qty[47:0], average_price[95:48], realized_profit[159:96],
  // open_order_count[164:160], zero pad[167:165]
  output logic [167:0] out_tdata,
  // tuser: status[2:0]
  output logic [2:0]   out_tuser
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [47:0] pos, avg;
  logic [63:0] prof;
  logic [4:0]  cnt;

  fpot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fpot_dp #(.ORDER_SLOTS(ORDER_SLOTS)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_kind              (in_tuser),
    .in_order_id          (in_tdata[63:0]),
    .in_qty               (in_tdata[95:64]),
    .in_price             (in_tdata[143:96]),
    .out_valid            (out_tvalid),
    .out_ready            (out_tready),
    .out_position_qty     (pos),
    .out_average_price    (avg),
    .out_realized_profit  (prof),
    .out_open_order_count (cnt),
    .out_status           (out_tuser)
  );

  assign out_tdata = {3'b000, cnt, prof, avg, pos};
endmodule
